FILE: hdl/mpeq_pkg.sv
// shared types, codes and control store for the matrix product element query block
`timescale 1ns / 1ps

package mpeq_pkg;

    localparam int STEP_W = 4;

    // request types
    localparam logic [1:0] REQ_WR_A = 2'd0;
    localparam logic [1:0] REQ_WR_B = 2'd1;
    localparam logic [1:0] REQ_RD   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [1:0] CFG_COLS_B    = 2'd2;

    localparam logic [4:0] CFG_RESET = 5'd2;

    // program steps
    localparam logic [STEP_W-1:0] ST_FETCH  = 4'd0;
    localparam logic [STEP_W-1:0] ST_DECODE = 4'd1;
    localparam logic [STEP_W-1:0] ST_WR_A   = 4'd2;
    localparam logic [STEP_W-1:0] ST_WR_B   = 4'd3;
    localparam logic [STEP_W-1:0] ST_CLR    = 4'd4;
    localparam logic [STEP_W-1:0] ST_MAC    = 4'd5;
    localparam logic [STEP_W-1:0] ST_DRAIN1 = 4'd6;
    localparam logic [STEP_W-1:0] ST_DRAIN2 = 4'd7;
    localparam logic [STEP_W-1:0] ST_RES    = 4'd8;
    localparam logic [STEP_W-1:0] ST_ERR    = 4'd9;

    // jump conditions
    localparam logic [1:0] JC_NEXT     = 2'd0;
    localparam logic [1:0] JC_GOTO     = 2'd1;
    localparam logic [1:0] JC_DISPATCH = 2'd2;
    localparam logic [1:0] JC_LOOP     = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [3:0]        row_index;
        logic [3:0]        col_index;
        logic signed [15:0] element_value;
    } t_req;

    typedef struct packed {
        logic signed [35:0] product_value;
        logic               index_error;
    } t_res;

    typedef struct packed {
        logic              wait_in;
        logic              wait_out;
        logic              accept;
        logic              wr_a;
        logic              wr_b;
        logic              clr;
        logic              issue;
        logic              ld_res;
        logic              ld_err;
        logic [1:0]        jc;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic accept;
        logic wr_a;
        logic wr_b;
        logic clr;
        logic issue;
        logic ld_res;
        logic ld_err;
    } t_ctrl;

    typedef struct packed {
        logic [1:0] req_type;
        logic       rd_ok;
        logic       k_last;
        logic       out_busy;
    } t_stat;

    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '0;
        unique case (step)
            ST_FETCH: begin
                w.wait_in = 1'b1;
                w.accept  = 1'b1;
                w.jc      = JC_NEXT;
            end
            ST_DECODE: begin
                w.jc = JC_DISPATCH;
            end
            ST_WR_A: begin
                w.wr_a   = 1'b1;
                w.jc     = JC_GOTO;
                w.target = ST_FETCH;
            end
            ST_WR_B: begin
                w.wr_b   = 1'b1;
                w.jc     = JC_GOTO;
                w.target = ST_FETCH;
            end
            ST_CLR: begin
                w.clr = 1'b1;
                w.jc  = JC_NEXT;
            end
            ST_MAC: begin
                w.issue  = 1'b1;
                w.jc     = JC_LOOP;
                w.target = ST_MAC;
            end
            ST_DRAIN1: begin
                w.jc = JC_NEXT;
            end
            ST_DRAIN2: begin
                w.jc = JC_NEXT;
            end
            ST_RES: begin
                w.wait_out = 1'b1;
                w.ld_res   = 1'b1;
                w.jc       = JC_GOTO;
                w.target   = ST_FETCH;
            end
            ST_ERR: begin
                w.wait_out = 1'b1;
                w.ld_err   = 1'b1;
                w.jc       = JC_GOTO;
                w.target   = ST_FETCH;
            end
            default: begin
                w.jc     = JC_GOTO;
                w.target = ST_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/mpeq_sequencer.sv
// step counter, control store lookup and jump logic
`timescale 1ns / 1ps

module mpeq_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mpeq_pkg::t_stat   i_stat,
    output logic              o_in_ready,
    output mpeq_pkg::t_ctrl   o_ctrl
);

    logic [mpeq_pkg::STEP_W-1:0] r_pc;
    logic [mpeq_pkg::STEP_W-1:0] n_pc;
    logic [mpeq_pkg::STEP_W-1:0] dispatch;
    mpeq_pkg::t_uword            uw;
    logic                        stall;

    assign uw    = mpeq_pkg::ucode(r_pc);
    assign stall = (uw.wait_in && !i_in_valid) || (uw.wait_out && i_stat.out_busy);

    assign o_in_ready = uw.accept;

    assign o_ctrl.accept = uw.accept & ~stall;
    assign o_ctrl.wr_a   = uw.wr_a & ~stall;
    assign o_ctrl.wr_b   = uw.wr_b & ~stall;
    assign o_ctrl.clr    = uw.clr & ~stall;
    assign o_ctrl.issue  = uw.issue & ~stall;
    assign o_ctrl.ld_res = uw.ld_res & ~stall;
    assign o_ctrl.ld_err = uw.ld_err & ~stall;

    always_comb begin
        unique case (i_stat.req_type)
            mpeq_pkg::REQ_WR_A: dispatch = mpeq_pkg::ST_WR_A;
            mpeq_pkg::REQ_WR_B: dispatch = mpeq_pkg::ST_WR_B;
            mpeq_pkg::REQ_RD:   dispatch = i_stat.rd_ok ? mpeq_pkg::ST_CLR : mpeq_pkg::ST_ERR;
            default:            dispatch = mpeq_pkg::ST_FETCH;
        endcase
    end

    always_comb begin
        n_pc = r_pc;
        if (!stall) begin
            unique case (uw.jc)
                mpeq_pkg::JC_NEXT:     n_pc = r_pc + 1'b1;
                mpeq_pkg::JC_GOTO:     n_pc = uw.target;
                mpeq_pkg::JC_DISPATCH: n_pc = dispatch;
                mpeq_pkg::JC_LOOP:     n_pc = i_stat.k_last ? r_pc + 1'b1 : uw.target;
                default:               n_pc = mpeq_pkg::ST_FETCH;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= mpeq_pkg::ST_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

FILE: hdl/mpeq_datapath.sv
// configuration, element stores, multiply-accumulate and result register
`timescale 1ns / 1ps

module mpeq_datapath #(
    parameter int MAX_DIM = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [4:0]      i_cfg_data,
    input  mpeq_pkg::t_req  i_in_data,
    input  mpeq_pkg::t_ctrl i_ctrl,
    input  logic            i_out_ready,
    output mpeq_pkg::t_stat o_stat,
    output logic            o_out_valid,
    output mpeq_pkg::t_res  o_out_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(MAX_DIM);
    localparam int EW    = $clog2(MAX_DIM + 1);

    logic [4:0]         r_rows_a;
    logic [4:0]         r_inner_dim;
    logic [4:0]         r_cols_b;
    logic [EW-1:0]      na;
    logic [EW-1:0]      nk;
    logic [EW-1:0]      nb;

    mpeq_pkg::t_req     r_req;
    logic [KW-1:0]      r_k;
    logic               a_ok;
    logic               b_ok;
    logic               rd_ok;
    logic               k_last;

    logic signed [15:0] mem_a [DEPTH];
    logic signed [15:0] mem_b [DEPTH];
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr_a;
    logic [AW-1:0]      rd_addr_b;

    logic signed [15:0] r_a_q;
    logic signed [15:0] r_b_q;
    logic               r_rd_v;
    logic signed [31:0] r_prod;
    logic               r_prod_v;
    logic signed [35:0] r_acc;

    logic               r_out_valid;
    mpeq_pkg::t_res     r_out;
    logic               out_busy;

    function automatic logic [EW-1:0] eff_size(input logic [4:0] v);
        logic [EW-1:0] s;
        if (v == 5'd0) begin
            s = EW'(1);
        end else if (32'(v) > MAX_DIM) begin
            s = EW'(MAX_DIM);
        end else begin
            s = EW'(v);
        end
        return s;
    endfunction

    assign na = eff_size(r_rows_a);
    assign nk = eff_size(r_inner_dim);
    assign nb = eff_size(r_cols_b);

    assign a_ok   = (32'(r_req.row_index) < 32'(na)) && (32'(r_req.col_index) < 32'(nk));
    assign b_ok   = (32'(r_req.row_index) < 32'(nk)) && (32'(r_req.col_index) < 32'(nb));
    assign rd_ok  = (32'(r_req.row_index) < 32'(na)) && (32'(r_req.col_index) < 32'(nb));
    assign k_last = (32'(r_k) == 32'(nk) - 32'd1);

    assign wr_addr   = AW'(32'(r_req.row_index) * MAX_DIM + 32'(r_req.col_index));
    assign rd_addr_a = AW'(32'(r_req.row_index) * MAX_DIM + 32'(r_k));
    assign rd_addr_b = AW'(32'(r_k) * MAX_DIM + 32'(r_req.col_index));

    assign out_busy = r_out_valid && !i_out_ready;

    assign o_stat.req_type = r_req.req_type;
    assign o_stat.rd_ok    = rd_ok;
    assign o_stat.k_last   = k_last;
    assign o_stat.out_busy = out_busy;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= mpeq_pkg::CFG_RESET;
            r_inner_dim <= mpeq_pkg::CFG_RESET;
            r_cols_b    <= mpeq_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mpeq_pkg::CFG_ROWS_A:    r_rows_a    <= i_cfg_data;
                mpeq_pkg::CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                mpeq_pkg::CFG_COLS_B:    r_cols_b    <= i_cfg_data;
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_req <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_a && a_ok) begin
            mem_a[wr_addr] <= r_req.element_value;
        end
        if (i_ctrl.issue) begin
            r_a_q <= mem_a[rd_addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_b && b_ok) begin
            mem_b[wr_addr] <= r_req.element_value;
        end
        if (i_ctrl.issue) begin
            r_b_q <= mem_b[rd_addr_b];
        end
    end

    // term index and pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= '0;
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            if (i_ctrl.clr) begin
                r_k <= '0;
            end else if (i_ctrl.issue) begin
                r_k <= r_k + 1'b1;
            end
            r_rd_v   <= i_ctrl.issue;
            r_prod_v <= r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_v) begin
            r_prod <= r_a_q * r_b_q;
        end
        if (i_ctrl.clr) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + 36'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.ld_res || i_ctrl.ld_err) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_res) begin
            r_out.product_value <= r_acc;
            r_out.index_error   <= 1'b0;
        end else if (i_ctrl.ld_err) begin
            r_out.product_value <= '0;
            r_out.index_error   <= 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.ld_res || i_ctrl.ld_err) |-> !out_busy)
        else $error("result loaded while previous beat still waiting");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.index_error) |-> (r_out.product_value == '0))
        else $error("error beat carries nonzero product");

    a_issue_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.issue && k_last) |=> !i_ctrl.issue)
        else $error("term issued past inner dimension");

    a_pipe_empty_at_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.ld_res |-> (!r_rd_v && !r_prod_v))
        else $error("result taken before accumulation finished");
`endif

endmodule

FILE: hdl/matrix_product_element_query.sv
// top level of the matrix product element query block
`timescale 1ns / 1ps

// Holds two signed 16-bit matrices, A (rows_a x inner_dim) and B (inner_dim x cols_b),
// written one element per input beat, and answers a read of result element (i,j) with
// the exact dot product of row i of A and column j of B as one output beat; reads
// outside the result size give index_error with a zero product, out of range writes
// are dropped. A write beat steps through fetch, decode and write. An in-range read
// steps through fetch, decode, clear, one term per cycle through the single
// registered multiply-accumulate, two drain steps for its read and multiply stages,
// and a load of the output register; an out-of-range read steps through fetch,
// decode and an error load. The result loads only when the output register is free,
// so a held result stalls the next read at that last step. Stored elements are
// undefined until written; there is no clearing pass after reset.
module matrix_product_element_query #(
    parameter int MAX_DIM = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [4:0]     i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mpeq_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mpeq_pkg::t_res o_out_data
);

    mpeq_pkg::t_ctrl ctrl;
    mpeq_pkg::t_stat stat;

    mpeq_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_ctrl     (ctrl)
    );

    mpeq_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_ctrl      (ctrl),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
